// ----- rtl/pee_pkg.sv -----
// Shared types, constants and the control program of the postfix expression evaluator.
`default_nettype none

package pee_pkg;

  localparam int STACK_DEPTH = 128;
  localparam int VALUE_WIDTH = 16;

  localparam int TOKEN_W = 8;
  localparam int OUT_W   = 16;
  localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W  = $clog2(STACK_DEPTH);
  localparam int PC_W    = 4;

  localparam logic [TOKEN_W-1:0] CH_ZERO = 8'h30;
  localparam logic [TOKEN_W-1:0] CH_ADD  = 8'h2B;
  localparam logic [TOKEN_W-1:0] CH_SUB  = 8'h2D;
  localparam logic [TOKEN_W-1:0] CH_MUL  = 8'h2A;
  localparam logic [TOKEN_W-1:0] CH_DIV  = 8'h2F;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIV0  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    ACT_NOP,
    ACT_ACCEPT,
    ACT_READ,
    ACT_PUSH,
    ACT_UNDER,
    ACT_ALU,
    ACT_DZERO,
    ACT_DSTART,
    ACT_DWB,
    ACT_EMIT
  } act_t;

  typedef enum logic [3:0] {
    C_ALWAYS,
    C_NO_IN,
    C_IS_OP,
    C_CNT_LT2,
    C_IS_DIV,
    C_B_ZERO,
    C_DIV_BUSY,
    C_LAST,
    C_OUT_BUSY
  } cond_sel_t;

  typedef struct packed {
    act_t             act;
    cond_sel_t        cond;
    logic [PC_W-1:0]  tgt_hit;
    logic [PC_W-1:0]  tgt_miss;
  } uword_t;

  typedef struct packed {
    logic is_op;
    logic is_div;
    logic cnt_lt2;
    logic b_zero;
    logic last;
    logic div_busy;
  } dp_flags_t;

  typedef struct packed {
    logic      in_valid;
    logic      out_busy;
    dp_flags_t dp;
  } seq_flags_t;

  localparam logic [PC_W-1:0] STEP_FETCH  = 4'd0;
  localparam logic [PC_W-1:0] STEP_DECODE = 4'd1;
  localparam logic [PC_W-1:0] STEP_PUSH   = 4'd2;
  localparam logic [PC_W-1:0] STEP_CHECK  = 4'd3;
  localparam logic [PC_W-1:0] STEP_UNDER  = 4'd4;
  localparam logic [PC_W-1:0] STEP_SELECT = 4'd5;
  localparam logic [PC_W-1:0] STEP_ARITH  = 4'd6;
  localparam logic [PC_W-1:0] STEP_DIVCHK = 4'd7;
  localparam logic [PC_W-1:0] STEP_DZERO  = 4'd8;
  localparam logic [PC_W-1:0] STEP_DSTART = 4'd9;
  localparam logic [PC_W-1:0] STEP_DWAIT  = 4'd10;
  localparam logic [PC_W-1:0] STEP_DWB    = 4'd11;
  localparam logic [PC_W-1:0] STEP_EMIT   = 4'd12;

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      STEP_FETCH:  w = '{ACT_ACCEPT, C_NO_IN,    STEP_FETCH,  STEP_DECODE};
      STEP_DECODE: w = '{ACT_READ,   C_IS_OP,    STEP_CHECK,  STEP_PUSH};
      STEP_PUSH:   w = '{ACT_PUSH,   C_LAST,     STEP_EMIT,   STEP_FETCH};
      STEP_CHECK:  w = '{ACT_NOP,    C_CNT_LT2,  STEP_UNDER,  STEP_SELECT};
      STEP_UNDER:  w = '{ACT_UNDER,  C_LAST,     STEP_EMIT,   STEP_FETCH};
      STEP_SELECT: w = '{ACT_NOP,    C_IS_DIV,   STEP_DIVCHK, STEP_ARITH};
      STEP_ARITH:  w = '{ACT_ALU,    C_LAST,     STEP_EMIT,   STEP_FETCH};
      STEP_DIVCHK: w = '{ACT_NOP,    C_B_ZERO,   STEP_DZERO,  STEP_DSTART};
      STEP_DZERO:  w = '{ACT_DZERO,  C_LAST,     STEP_EMIT,   STEP_FETCH};
      STEP_DSTART: w = '{ACT_DSTART, C_ALWAYS,   STEP_DWAIT,  STEP_DWAIT};
      STEP_DWAIT:  w = '{ACT_NOP,    C_DIV_BUSY, STEP_DWAIT,  STEP_DWB};
      STEP_DWB:    w = '{ACT_DWB,    C_LAST,     STEP_EMIT,   STEP_FETCH};
      STEP_EMIT:   w = '{ACT_EMIT,   C_OUT_BUSY, STEP_EMIT,   STEP_FETCH};
      default:     w = '{ACT_NOP,    C_ALWAYS,   STEP_FETCH,  STEP_FETCH};
    endcase
    return w;
  endfunction

  function automatic logic [OUT_W-1:0] to_out(input logic [VALUE_WIDTH-1:0] v);
    logic signed [VALUE_WIDTH-1:0] sv;
    sv = v;
    return OUT_W'(sv);
  endfunction

  function automatic logic [VALUE_WIDTH-1:0] magnitude(input logic [VALUE_WIDTH-1:0] v);
    return v[VALUE_WIDTH-1] ? (~v + VALUE_WIDTH'(1)) : v;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/pee_div.sv -----
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none

module pee_div (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic [pee_pkg::VALUE_WIDTH-1:0]  dividend,
  input  wire logic [pee_pkg::VALUE_WIDTH-1:0]  divisor,
  output logic                                  busy,
  output logic [pee_pkg::VALUE_WIDTH-1:0]       quotient
);

  localparam int VW   = pee_pkg::VALUE_WIDTH;
  localparam int STEP_W = $clog2(VW + 1);

  logic [STEP_W-1:0] step_r;
  logic [VW-1:0]     rem_r;
  logic [VW-1:0]     quo_r;
  logic [VW-1:0]     dvs_r;
  logic              neg_r;
  logic [VW:0]       rem_shift;
  logic              fits;

  assign rem_shift = {rem_r, quo_r[VW-1]};
  assign fits      = rem_shift >= {1'b0, dvs_r};
  assign busy      = step_r != '0;
  assign quotient  = neg_r ? (~quo_r + VW'(1)) : quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (start) begin
      step_r <= STEP_W'(VW);
    end else if (busy) begin
      step_r <= step_r - STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= pee_pkg::magnitude(dividend);
      dvs_r <= pee_pkg::magnitude(divisor);
      neg_r <= dividend[VW-1] ^ divisor[VW-1];
    end else if (busy) begin
      rem_r <= fits ? VW'(rem_shift - {1'b0, dvs_r}) : VW'(rem_shift);
      quo_r <= {quo_r[VW-2:0], fits};
    end
  end

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n) start |=> busy)
    else $error("Divider did not go busy after start.");

endmodule

`default_nettype wire

// ----- rtl/pee_seq.sv -----
// Microcode sequencer: step counter, control program lookup and conditional jumps.
`default_nettype none

module pee_seq (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire pee_pkg::seq_flags_t  flags,
  output pee_pkg::act_t             act
);

  logic [pee_pkg::PC_W-1:0] pc_r;
  logic [pee_pkg::PC_W-1:0] pc_nxt;
  pee_pkg::uword_t          uw;
  logic                     hit;

  assign uw  = pee_pkg::ucode(pc_r);
  assign act = uw.act;

  always_comb begin
    case (uw.cond)
      pee_pkg::C_ALWAYS:   hit = 1'b1;
      pee_pkg::C_NO_IN:    hit = !flags.in_valid;
      pee_pkg::C_IS_OP:    hit = flags.dp.is_op;
      pee_pkg::C_CNT_LT2:  hit = flags.dp.cnt_lt2;
      pee_pkg::C_IS_DIV:   hit = flags.dp.is_div;
      pee_pkg::C_B_ZERO:   hit = flags.dp.b_zero;
      pee_pkg::C_DIV_BUSY: hit = flags.dp.div_busy;
      pee_pkg::C_LAST:     hit = flags.dp.last;
      pee_pkg::C_OUT_BUSY: hit = flags.out_busy;
      default:             hit = 1'b0;
    endcase
    pc_nxt = hit ? uw.tgt_hit : uw.tgt_miss;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= pee_pkg::STEP_FETCH;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pee_dp.sv -----
// Datapath: value stack memory with top-of-stack register, ALU, error tracking and divider.
`default_nettype none

module pee_dp (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire pee_pkg::act_t                      act,
  input  wire logic                               in_go,
  input  wire logic                               emit_go,
  input  wire logic [pee_pkg::TOKEN_W-1:0]        in_token,
  input  wire logic                               in_last,
  output pee_pkg::dp_flags_t                      flags,
  output logic [pee_pkg::OUT_W-1:0]               emit_value,
  output pee_pkg::status_t                        emit_status
);

  localparam int VW     = pee_pkg::VALUE_WIDTH;
  localparam int CNT_W  = pee_pkg::CNT_W;
  localparam int ADDR_W = pee_pkg::ADDR_W;

  logic [VW-1:0]               mem [pee_pkg::STACK_DEPTH];
  logic [VW-1:0]               rd_q_r;
  logic [VW-1:0]               tos_r;
  logic [VW-1:0]               tos_nxt;
  logic [CNT_W-1:0]            count_r;
  logic [CNT_W-1:0]            count_nxt;
  pee_pkg::status_t            err_r;
  pee_pkg::status_t            err_nxt;
  pee_pkg::status_t            err_raise;
  logic [pee_pkg::TOKEN_W-1:0] token_r;
  logic                        last_r;
  logic                        mem_we;
  logic [CNT_W-1:0]            wr_idx;
  logic [CNT_W-1:0]            rd_idx;
  logic [VW-1:0]               prod;
  logic [VW-1:0]               alu_res;
  logic [VW-1:0]               push_val;
  logic [VW-1:0]               emit_sel;
  logic                        div_busy;
  logic [VW-1:0]               div_q;

  assign wr_idx   = count_r - CNT_W'(1);
  assign rd_idx   = count_r - CNT_W'(2);
  assign prod     = rd_q_r * tos_r;
  assign push_val = VW'(token_r) - VW'(pee_pkg::CH_ZERO);

  always_comb begin
    flags.is_op    = token_r inside {pee_pkg::CH_ADD, pee_pkg::CH_SUB,
                                     pee_pkg::CH_MUL, pee_pkg::CH_DIV};
    flags.is_div   = token_r == pee_pkg::CH_DIV;
    flags.cnt_lt2  = count_r < CNT_W'(2);
    flags.b_zero   = tos_r == '0;
    flags.last     = last_r;
    flags.div_busy = div_busy;
  end

  always_comb begin
    case (token_r)
      pee_pkg::CH_ADD: alu_res = rd_q_r + tos_r;
      pee_pkg::CH_SUB: alu_res = rd_q_r - tos_r;
      default:         alu_res = prod;
    endcase
  end

  always_comb begin
    if (count_r == '0 && err_r == pee_pkg::ST_OK) begin
      emit_status = pee_pkg::ST_UNDER;
    end else begin
      emit_status = err_r;
    end
    emit_sel   = (count_r == '0 || emit_status != pee_pkg::ST_OK) ? '0 : tos_r;
    emit_value = pee_pkg::to_out(emit_sel);
  end

  always_comb begin
    count_nxt = count_r;
    tos_nxt   = tos_r;
    err_raise = pee_pkg::ST_OK;
    mem_we    = 1'b0;
    case (act)
      pee_pkg::ACT_PUSH: begin
        if (count_r == CNT_W'(pee_pkg::STACK_DEPTH)) begin
          err_raise = pee_pkg::ST_OVER;
        end else begin
          mem_we    = count_r != '0;
          tos_nxt   = push_val;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      pee_pkg::ACT_UNDER: begin
        err_raise = pee_pkg::ST_UNDER;
        tos_nxt   = '0;
        count_nxt = CNT_W'(1);
      end
      pee_pkg::ACT_ALU: begin
        tos_nxt   = alu_res;
        count_nxt = wr_idx;
      end
      pee_pkg::ACT_DZERO: begin
        err_raise = pee_pkg::ST_DIV0;
        tos_nxt   = '0;
        count_nxt = wr_idx;
      end
      pee_pkg::ACT_DWB: begin
        tos_nxt   = div_q;
        count_nxt = wr_idx;
      end
      pee_pkg::ACT_EMIT: begin
        if (emit_go) begin
          count_nxt = '0;
        end
      end
      default: begin
      end
    endcase
    if (emit_go) begin
      err_nxt = pee_pkg::ST_OK;
    end else if (err_r == pee_pkg::ST_OK) begin
      err_nxt = err_raise;
    end else begin
      err_nxt = err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      err_r   <= pee_pkg::ST_OK;
    end else begin
      count_r <= count_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tos_r <= tos_nxt;
    if (in_go) begin
      token_r <= in_token;
      last_r  <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx[ADDR_W-1:0]] <= tos_r;
    end
    if (act == pee_pkg::ACT_READ) begin
      rd_q_r <= mem[rd_idx[ADDR_W-1:0]];
    end
  end

  pee_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (act == pee_pkg::ACT_DSTART),
    .dividend (rd_q_r),
    .divisor  (tos_r),
    .busy     (div_busy),
    .quotient (div_q)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(pee_pkg::STACK_DEPTH))
    else $error("Stack count above depth.");

  a_emit_clear: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go |=> (count_r == '0 && err_r == pee_pkg::ST_OK))
    else $error("Stack or status not cleared after result.");

  a_alu_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (act == pee_pkg::ACT_ALU) |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("Binary operation did not shrink the stack by one.");

endmodule

`default_nettype wire

// ----- rtl/postfix_expression_evaluator_core.sv -----
// Top level of the postfix expression evaluator: sequencer, datapath and result register.
//
//   channel  direction  word               handshake
//   in_      input      token, last        in_valid / in_ready
//   out_     output     value, status      out_valid / out_ready
//
// A digit word runs fetch, decode and push; an add, subtract or multiply runs fetch,
// decode, check, select and arith; a divide replaces arith with divchk, dstart, dwait and
// dwb, dwait paced by the one-bit-per-cycle divider; a word marked last adds emit.
// Reset is synchronous and active low and leaves the stack empty with no error.
// A result waiting in the output register does not stop the next word from being
// taken; only the following result waits until out_ready frees the register.
`default_nettype none

module postfix_expression_evaluator_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [pee_pkg::TOKEN_W-1:0]   in_token,
  input  wire logic                          in_last,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [pee_pkg::OUT_W-1:0]          out_value,
  output logic [1:0]                         out_status
);

  pee_pkg::act_t              act;
  pee_pkg::seq_flags_t        flags;
  pee_pkg::dp_flags_t         dp_flags;
  logic [pee_pkg::OUT_W-1:0]  emit_value;
  pee_pkg::status_t           emit_status;
  logic                       in_go;
  logic                       emit_go;
  logic                       out_valid_r;
  logic [pee_pkg::OUT_W-1:0]  out_value_r;
  pee_pkg::status_t           out_status_r;

  assign in_ready   = act == pee_pkg::ACT_ACCEPT;
  assign in_go      = in_valid && in_ready;
  assign emit_go    = (act == pee_pkg::ACT_EMIT) && !out_valid_r;
  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  always_comb begin
    flags.in_valid = in_valid;
    flags.out_busy = out_valid_r;
    flags.dp       = dp_flags;
  end

  pee_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .act   (act)
  );

  pee_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .act         (act),
    .in_go       (in_go),
    .emit_go     (emit_go),
    .in_token    (in_token),
    .in_last     (in_last),
    .flags       (dp_flags),
    .emit_value  (emit_value),
    .emit_status (emit_status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_value_r  <= emit_value;
      out_status_r <= emit_status;
    end
  end

  a_err_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != pee_pkg::ST_OK) |-> out_value == '0)
    else $error("Result value not zero on an error status.");

endmodule

`default_nettype wire
